### rtl/ip_id_sequence_anomaly_table_unit_assert.svh
// assertion macros shared by the anomaly table modules
// expects i_clk and i_rst_n in the scope of use
`ifndef IP_ID_SEQUENCE_ANOMALY_TABLE_UNIT_ASSERT_SVH
`define IP_ID_SEQUENCE_ANOMALY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ISAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ISAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/isat_pkg.sv
// shared types, constants and helpers for the ip identification anomaly table
// no dependencies
package isat_pkg;

    localparam int MAX_PAIRS = 16;
    localparam int SLOT_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PSLOT_W   = 4;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [MAX_PAIRS-1:0] t_vec;

    // input packet
    typedef struct packed {
        logic        first_of_batch;
        logic        last_of_batch;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ip_ident;
    } t_in_item;

    // per-batch result
    typedef struct packed {
        logic [PSLOT_W-1:0] pair_slot;
        logic               new_pair;
        logic               table_full;
        logic [15:0]        anomaly_count;
    } t_out_item;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic step;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } t_sts;

    // entry index shown on the 4-bit slot field, low bits only
    function automatic logic [PSLOT_W-1:0] f_pair_slot(input t_slot s);
        logic [SLOT_W+PSLOT_W-1:0] w;
        w = {{PSLOT_W{1'b0}}, s};
        return w[PSLOT_W-1:0];
    endfunction

endpackage

### rtl/isat_datapath.sv
// datapath: packet register, pair table with parallel compare, batch tracking
// depends on isat_pkg and the assertion macro header
`include "ip_id_sequence_anomaly_table_unit_assert.svh"

module isat_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isat_pkg::t_in_item  i_in_item,
    input  isat_pkg::t_cmd      i_cmd,
    output isat_pkg::t_sts      o_sts,
    output isat_pkg::t_out_item o_out_item
);

    // captured packet
    isat_pkg::t_in_item r_pkt;

    // pair table
    logic [31:0]     r_src [isat_pkg::MAX_PAIRS];
    logic [31:0]     r_dst [isat_pkg::MAX_PAIRS];
    isat_pkg::t_vec  r_valid, n_valid;

    // batch state
    isat_pkg::t_slot r_slot, n_slot;
    logic            r_untracked, n_untracked;
    logic            r_new, n_new;
    logic [15:0]     r_expected;
    logic [15:0]     r_count, n_count;
    logic            r_open;

    // result register
    isat_pkg::t_out_item r_out;

    // lookup results
    isat_pkg::t_vec  w_match;
    logic            w_hit, w_have_free, w_open_now, w_alloc;
    isat_pkg::t_slot w_hit_slot, w_free_slot;
    logic [15:0]     w_exp_base, w_cnt_base;

    assign o_sts.last = r_pkt.last_of_batch;
    assign o_out_item = r_out;

    // packet capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pkt <= i_in_item;
        end
    end

    // parallel compare against all entries, lowest index wins
    always_comb begin
        w_hit_slot  = '0;
        w_free_slot = '0;
        for (int i = 0; i < isat_pkg::MAX_PAIRS; i++) begin
            w_match[i] = r_valid[i] && (r_src[i] == r_pkt.src_addr)
                         && (r_dst[i] == r_pkt.dst_addr);
        end
        for (int i = isat_pkg::MAX_PAIRS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_slot = isat_pkg::t_slot'(i);
            end
            if (!r_valid[i]) begin
                w_free_slot = isat_pkg::t_slot'(i);
            end
        end
        w_hit       = |w_match;
        w_have_free = ~&r_valid;
    end

    // batch open decision and anomaly counting
    always_comb begin
        w_open_now  = r_pkt.first_of_batch || !r_open;
        w_alloc     = w_open_now && !w_hit && w_have_free;
        n_slot      = r_slot;
        n_untracked = r_untracked;
        n_new       = r_new;
        n_valid     = r_valid;
        w_exp_base  = r_expected;
        w_cnt_base  = r_count;
        if (w_open_now) begin
            w_exp_base = r_pkt.ip_ident;
            w_cnt_base = '0;
            if (w_hit) begin
                n_slot      = w_hit_slot;
                n_untracked = 1'b0;
                n_new       = 1'b0;
            end else if (w_have_free) begin
                n_slot               = w_free_slot;
                n_untracked          = 1'b0;
                n_new                = 1'b1;
                n_valid[w_free_slot] = 1'b1;
            end else begin
                n_slot      = '0;
                n_untracked = 1'b1;
                n_new       = 1'b0;
            end
        end
        n_count = w_cnt_base;
        if ((r_pkt.ip_ident != w_exp_base) && (w_cnt_base != 16'hFFFF)) begin
            n_count = w_cnt_base + 16'd1;
        end
    end

    // control state of the batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_slot      <= '0;
            r_untracked <= 1'b0;
            r_new       <= 1'b0;
            r_expected  <= '0;
            r_count     <= '0;
            r_open      <= 1'b0;
        end else if (i_cmd.step) begin
            r_valid     <= n_valid;
            r_slot      <= n_slot;
            r_untracked <= n_untracked;
            r_new       <= n_new;
            r_expected  <= r_pkt.ip_ident + 16'd1;
            r_count     <= n_count;
            r_open      <= !r_pkt.last_of_batch;
        end
    end

    // entry write on allocation
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_alloc) begin
            r_src[w_free_slot] <= r_pkt.src_addr;
            r_dst[w_free_slot] <= r_pkt.dst_addr;
        end
    end

    // result load on the last packet of a batch
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.pair_slot     <= n_untracked ? '0 : isat_pkg::f_pair_slot(n_slot);
            r_out.new_pair      <= n_new;
            r_out.table_full    <= n_untracked;
            r_out.anomaly_count <= n_count;
        end
    end

    // a pair is held by at most one entry
    `ISAT_ASSERT_NOW(a_unique_pair, 1'b1, $onehot0(w_match), "pair held by two entries")
    // untracked batches never claim a new entry
    `ISAT_ASSERT_NOW(a_untracked_not_new, r_untracked, !r_new, "untracked batch marked new")
    // an allocation leaves its entry valid
    `ISAT_ASSERT_NEXT(a_alloc_valid, i_cmd.step && w_alloc, r_valid[$past(w_free_slot)],
        "allocated entry not valid")

endmodule

### rtl/isat_ctrl.sv
// controller: packet handshake, execute sequencing and result register occupancy
// depends on isat_pkg and the assertion macro header
`include "ip_id_sequence_anomaly_table_unit_assert.svh"

module isat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  isat_pkg::t_sts  i_sts,
    output isat_pkg::t_cmd  o_cmd
);

    isat_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // state and result occupancy registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isat_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            isat_pkg::ST_IDLE: begin
                // no transfer is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = isat_pkg::ST_EXEC;
                end
            end
            isat_pkg::ST_EXEC: begin
                // a last packet waits until the result register can take it
                if (!i_sts.last || w_out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.emit = i_sts.last;
                    n_state    = isat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = isat_pkg::ST_IDLE;
            end
        endcase
    end

    // result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // a waiting result is never overwritten
    `ISAT_ASSERT_NOW(a_no_overwrite, o_cmd.emit, w_out_free, "result overwritten")
    // the table is only stepped with a captured packet
    `ISAT_ASSERT_NOW(a_step_in_exec, o_cmd.step, r_state == isat_pkg::ST_EXEC,
        "step outside execute")
    // a captured packet is executed next
    `ISAT_ASSERT_NEXT(a_capture_exec, o_cmd.capture, r_state == isat_pkg::ST_EXEC,
        "capture not followed by execute")

endmodule

### rtl/ip_id_sequence_anomaly_table_unit.sv
// ip identification sequence anomaly table, top level
// instantiates isat_ctrl and isat_datapath; depends on isat_pkg
//
// packets enter on the input channel (i_in_valid / o_in_ready, payload
// i_in_item); one result per batch leaves on the output channel
// (o_out_valid / i_out_ready, payload o_out_item), only for a packet with
// last_of_batch set.
// each packet is first registered, then in the execute step its pair is compared
// against all table entries in parallel and the batch state is updated; a new
// packet is taken only after the execute step of the packet before it is done.
// a result is loaded from the packet register into an output register in its
// packet's execute step; the next packet is taken while it waits.
// if the receiver stalls, a following last packet holds in the execute step
// until the waiting result transfers, and input stalls behind it.
// reset (synchronous, active low) empties the table, closes any open batch
// and drops a result not yet transferred; no packet is taken during reset
// and the block is ready as soon as reset is released.
module ip_id_sequence_anomaly_table_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  isat_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output isat_pkg::t_out_item o_out_item
);

    isat_pkg::t_cmd w_cmd;
    isat_pkg::t_sts w_sts;

    // sequencing and handshakes
    isat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // table and batch tracking
    isat_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_item (o_out_item)
    );

endmodule
